// File: design/cbs_pkg.sv
// cbs_pkg: shared types and constants of the cubic bezier curve sampler
// no dependencies; imported by the interfaces, the datapath modules and the checker

package cbs_pkg;

  localparam int COORD_W = 24;
  localparam int STEP_W  = 17;
  localparam int T_W     = 16;
  localparam int U_W     = 17;
  localparam int WGT_W   = 49;
  localparam int ACC_W   = 72;
  localparam int MA_W    = 33;
  localparam int MB_W    = 25;
  localparam int PROD_W  = MA_W + MB_W;

  localparam logic [U_W-1:0]     T_ONE       = 17'h10000;
  localparam logic [COORD_W-1:0] COORD_BIAS  = 24'h800000;
  localparam logic [ACC_W-1:0]   ACC_ROUND   = 72'h00_8000_0000_0000;
  localparam logic [STEP_W-1:0]  T_STEP_INIT = 17'd4096;

  // register index, taken from paddr[2]
  localparam logic REG_T_STEP = 1'b0;

  // sequencer steps of one sample: six weight products, sixteen coordinate products, drain
  localparam logic [4:0] S_UU    = 5'd0;
  localparam logic [4:0] S_TT    = 5'd1;
  localparam logic [4:0] S_U2U   = 5'd2;
  localparam logic [4:0] S_U2T   = 5'd3;
  localparam logic [4:0] S_T2U   = 5'd4;
  localparam logic [4:0] S_T2T   = 5'd5;
  localparam logic [4:0] S_COORD = 5'd6;
  localparam logic [4:0] S_XDONE = 5'd14;
  localparam logic [4:0] S_DRAIN = 5'd22;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic busy;
    logic emit;
    logic last;
  } cbs_stat_t;

endpackage

// File: design/cbs_stream_ifs.sv
// cbs_stream_ifs: valid/ready channels for control points and curve samples
// depends on cbs_pkg for field widths

interface cbs_point_if import cbs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  point_x;
  logic signed [COORD_W-1:0]  point_y;
  logic                       curve_start;

  modport source(output valid, point_x, point_y, curve_start, input ready);
  modport sink(input valid, point_x, point_y, curve_start, output ready);
endinterface

interface cbs_sample_if import cbs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  sample_x;
  logic signed [COORD_W-1:0]  sample_y;
  logic                       segment_last;

  modport source(output valid, sample_x, sample_y, segment_last, input ready);
  modport sink(input valid, sample_x, sample_y, segment_last, output ready);
endinterface

// File: design/cbs_mul.sv
// cbs_mul: shared unsigned multiplier with registered product
// depends on cbs_pkg for operand widths

module cbs_mul import cbs_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [MA_W-1:0]   a,
  input  logic [MB_W-1:0]   b,
  output logic [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

// File: design/cbs_eval.sv
// cbs_eval: sample sequencer, bernstein weights and exact weighted sums
// depends on cbs_pkg and cbs_mul (one multiplier shared by every product)

module cbs_eval import cbs_pkg::*; #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [STEP_W-1:0]   t_step,
  input  point_t [3:0]        pts,
  input  logic                out_free,
  output cbs_stat_t           stat,
  output logic [COORD_W-1:0]  sample_x,
  output logic [COORD_W-1:0]  sample_y
);

  localparam int NW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  logic                busy;
  logic [4:0]          step;
  logic [T_W-1:0]      t;
  logic [NW-1:0]       n;
  logic [MA_W-1:0]     u2;
  logic [MA_W-1:0]     t2;
  logic [WGT_W-1:0]    w [4];
  logic [ACC_W-1:0]    acc;
  logic [COORD_W-1:0]  sx;

  logic [U_W-1:0]      u;
  logic [T_W+1:0]      t_sum;
  logic                last;
  logic                mul_en;
  logic [MA_W-1:0]     mul_a;
  logic [MB_W-1:0]     mul_b;
  logic [PROD_W-1:0]   prod;
  logic [4:0]          ij;
  logic [4:0]          cs;
  logic [4:0]          cj;
  logic [COORD_W-1:0]  coord;
  logic [ACC_W-1:0]    term;
  logic [ACC_W-1:0]    base;
  logic [ACC_W-1:0]    acc_sum;
  logic [WGT_W-1:0]    triple;

  assign u      = T_ONE - {1'b0, t};
  assign t_sum  = {2'b00, t} + {1'b0, t_step};
  assign last   = (n == NW'(MAX_SAMPLES - 1)) || (t_sum[T_W+1:T_W] != 2'b00);
  assign mul_en = busy && (step != S_DRAIN);

  // issue side: operands of the product started this cycle
  always_comb begin
    ij    = step - S_COORD;
    coord = (ij[3] ? pts[ij[2:1]].y : pts[ij[2:1]].x) ^ COORD_BIAS;
    unique case (step)
      S_UU: begin
        mul_a = MA_W'(u);
        mul_b = MB_W'(u);
      end
      S_TT: begin
        mul_a = MA_W'(t);
        mul_b = MB_W'(t);
      end
      S_U2U: begin
        mul_a = u2;
        mul_b = MB_W'(u);
      end
      S_U2T: begin
        mul_a = u2;
        mul_b = MB_W'(t);
      end
      S_T2U: begin
        mul_a = t2;
        mul_b = MB_W'(u);
      end
      S_T2T: begin
        mul_a = t2;
        mul_b = MB_W'(t);
      end
      default: begin
        mul_a = MA_W'(coord);
        mul_b = ij[0] ? {1'b0, w[ij[2:1]][23:0]} : w[ij[2:1]][WGT_W-1:24];
      end
    endcase
  end

  cbs_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // consume side: the product issued one step earlier
  always_comb begin
    cs      = step - 5'd1;
    cj      = cs - S_COORD;
    term    = cj[0] ? {24'b0, prod[47:0]} : {prod[47:0], 24'b0};
    base    = (cj[2:1] == 2'd0 && !cj[0]) ? ACC_ROUND : acc;
    acc_sum = base + term;
    triple  = prod[WGT_W-1:0] + {prod[WGT_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (busy && step != S_UU) begin
      unique case (cs)
        S_UU:  u2   <= prod[MA_W-1:0];
        S_TT:  t2   <= prod[MA_W-1:0];
        S_U2U: w[0] <= prod[WGT_W-1:0];
        S_U2T: w[1] <= triple;
        S_T2U: w[2] <= triple;
        S_T2T: w[3] <= prod[WGT_W-1:0];
        default: begin
          // the y sum stays live in acc_sum while the result waits
          if (step != S_DRAIN) begin
            acc <= acc_sum;
          end
          if (step == S_XDONE) begin
            sx <= acc_sum[ACC_W-1:ACC_W-COORD_W] ^ COORD_BIAS;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= S_UU;
      t    <= '0;
      n    <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= S_UU;
      t    <= '0;
      n    <= '0;
    end else if (busy) begin
      if (step == S_DRAIN) begin
        if (out_free) begin
          if (last) begin
            busy <= 1'b0;
          end else begin
            step <= S_UU;
            t    <= t_sum[T_W-1:0];
            n    <= n + NW'(1);
          end
        end
      end else begin
        step <= step + 5'd1;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.emit = busy && (step == S_DRAIN) && out_free;
  assign stat.last = last;
  assign sample_x  = sx;
  assign sample_y  = acc_sum[ACC_W-1:ACC_W-COORD_W] ^ COORD_BIAS;

endmodule

// File: design/cubic_bezier_curve_sampler_top.sv
// Cubic bezier curve sampler. Control points arrive on the points channel; a flagged point
// (or the first point after reset) anchors a curve, and every third point after it closes a
// segment that shares its first point with the end of the previous one. Each point that does
// not close a segment is taken while idle. A closing point starts the sampling of the
// segment at t = 0, t_step, 2*t_step, ... while t < 1, at most MAX_SAMPLES samples, and the
// points channel stays not ready until the last sample has entered the output register. Every
// sample is computed on the one shared 33x25 multiplier in steps: six products for the
// Bernstein weights, sixteen for the two coordinate sums, then a drain of the product
// register that waits while the output stays stalled. Results are rounded half up to Q15.8.
// t_step is written over the APB port at address 0.
// cubic_bezier_curve_sampler_top: point window, APB register, output register
// depends on cbs_pkg, cbs_stream_ifs and cbs_eval

module cubic_bezier_curve_sampler_top import cbs_pkg::*; #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic         clk,
  input  logic         rst,
  cbs_point_if.sink    points,
  cbs_sample_if.source samples,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [STEP_W-1:0]   t_step;
  logic [1:0]          phase;
  logic                have_anchor;
  point_t [3:0]        window;
  logic                out_valid;
  logic [COORD_W-1:0]  out_x;
  logic [COORD_W-1:0]  out_y;
  logic                out_last;

  cbs_stat_t           stat;
  logic [COORD_W-1:0]  eval_x;
  logic [COORD_W-1:0]  eval_y;
  logic                out_free;
  logic                accept;
  logic                anchor;
  logic                closes;
  logic                cfg_wr;
  logic [1:0]          phase_inc;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_T_STEP) ? {15'b0, t_step} : '0;

  assign points.ready = !stat.busy;
  assign accept    = points.valid && points.ready;
  assign anchor    = points.curve_start || !have_anchor;
  assign phase_inc = phase + 2'd1;
  assign closes    = accept && !anchor && (phase_inc == 2'd3);
  assign out_free  = !out_valid || samples.ready;

  cbs_eval #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_eval (
    .clk      (clk),
    .rst      (rst),
    .start    (closes),
    .t_step   (t_step),
    .pts      (window),
    .out_free (out_free),
    .stat     (stat),
    .sample_x (eval_x),
    .sample_y (eval_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      t_step      <= T_STEP_INIT;
      phase       <= 2'd0;
      have_anchor <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_T_STEP) begin
        t_step <= pwdata[STEP_W-1:0];
      end
      if (accept) begin
        have_anchor <= 1'b1;
        if (anchor || closes) begin
          phase <= 2'd0;
        end else begin
          phase <= phase_inc;
        end
      end
      if (stat.emit) begin
        out_valid <= 1'b1;
      end else if (samples.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (anchor) begin
        window[0] <= '{x: points.point_x, y: points.point_y};
      end else begin
        window[phase_inc] <= '{x: points.point_x, y: points.point_y};
      end
    end
    // the closing point becomes the first point of the next segment
    if (stat.emit && stat.last) begin
      window[0] <= window[3];
    end
    if (stat.emit) begin
      out_x    <= eval_x;
      out_y    <= eval_y;
      out_last <= stat.last;
    end
  end

  assign samples.valid        = out_valid;
  assign samples.sample_x     = out_x;
  assign samples.sample_y     = out_y;
  assign samples.segment_last = out_last;

endmodule

// File: design/cbs_checker.sv
// cbs_checker: port-level checks of the curve sampler and its bind
// depends on cbs_pkg; attaches to cubic_bezier_curve_sampler_top

module cbs_checker import cbs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COORD_W-1:0] out_x,
  input logic [COORD_W-1:0] out_y,
  input logic               out_last
);

  // a stalled sample beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_last))
    else $error("stalled sample beat changed");

  // sampling only starts on an accepted point
  a_busy_on_accept: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("point channel went busy without a point beat");

  // a new sample appears only while sampling is under way
  a_sample_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("sample beat appeared while idle");

  // sampling ends with the flagged last sample in the output register
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(in_ready) |-> out_valid && out_last)
    else $error("point channel ready again without a last sample");

endmodule

bind cubic_bezier_curve_sampler_top cbs_checker u_cbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (points.valid),
  .in_ready  (points.ready),
  .out_valid (samples.valid),
  .out_ready (samples.ready),
  .out_x     (samples.sample_x),
  .out_y     (samples.sample_y),
  .out_last  (samples.segment_last)
);

// File: tb/sv/cubic_bezier_curve_sampler_top_tb.sv
// cubic_bezier_curve_sampler_top_tb: self-checking bench that streams control points, predicts
// every bezier sample in fixed point, and checks the sample stream field by field
// depends on cbs_pkg, cbs_stream_ifs and the cubic_bezier_curve_sampler_top rtl

module cubic_bezier_curve_sampler_top_tb import cbs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SAMPLES = 64;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE      = 40;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 24;

  // second register slot, no register behind it
  localparam logic REG_UNUSED = 1'b1;

  localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      start;
  } ctrl_point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } curve_sample_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cbs_point_if  point_bus ();
  cbs_sample_if sample_bus ();

  cubic_bezier_curve_sampler_top #(.MAX_SAMPLES(MAX_SAMPLES)) u_top (
    .clk     (clk),
    .rst     (rst),
    .points  (point_bus.sink),
    .samples (sample_bus.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [COORD_W-1:0] win_x [4];
  logic [COORD_W-1:0] win_y [4];
  logic [1:0]         seg_phase;
  logic               anchored;
  logic [STEP_W-1:0]  step_cfg;

  ctrl_point_t   point_feed [$];
  curve_sample_t expected_samples [$];
  int            error_count = 0;

  // sender burst shaping
  int burst_left = 1;
  int gap_left   = 0;

  // receiver stall shaping
  int            ready_pct = 100;
  int            rx_cycles = 0;
  int            hold_seq  = 0;
  int            hold_ack;
  int            hold_left;
  curve_sample_t got;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // accept one control point and queue the samples it releases
  task automatic take_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                            input logic start);
    logic [17:0]      t;
    logic [U_W-1:0]   u;
    logic [U_W-1:0]   tt;
    logic [WGT_W-1:0] w [4];
    logic [79:0]      acc_x;
    logic [79:0]      acc_y;
    curve_sample_t    smp;
    int               n;
    if (start || !anchored) begin
      win_x[0]  = px;
      win_y[0]  = py;
      seg_phase = 2'd0;
      anchored  = 1'b1;
      return;
    end
    seg_phase = seg_phase + 2'd1;
    win_x[seg_phase] = px;
    win_y[seg_phase] = py;
    if (seg_phase != 2'd3) return;
    t = '0;
    n = 0;
    while (n < MAX_SAMPLES && t < T_ONE) begin
      tt   = t[U_W-1:0];
      u    = T_ONE - tt;
      w[0] = u * u * u;
      w[1] = 49'd3 * u * u * tt;
      w[2] = 49'd3 * u * tt * tt;
      w[3] = tt * tt * tt;
      acc_x = '0;
      acc_y = '0;
      for (int k = 0; k < 4; k++) begin
        acc_x = acc_x + (win_x[k] ^ COORD_BIAS) * w[k];
        acc_y = acc_y + (win_y[k] ^ COORD_BIAS) * w[k];
      end
      // weights sum to 2^48: round half up back to q15.8
      acc_x = (acc_x + (80'd1 << 47)) >> 48;
      acc_y = (acc_y + (80'd1 << 47)) >> 48;
      smp.x = acc_x[COORD_W-1:0] ^ COORD_BIAS;
      smp.y = acc_y[COORD_W-1:0] ^ COORD_BIAS;
      t = t + step_cfg;
      n++;
      smp.last = !(n < MAX_SAMPLES && t < T_ONE);
      expected_samples = {expected_samples, smp};
    end
    win_x[0]  = win_x[3];
    win_y[0]  = win_y[3];
    seg_phase = 2'd0;
  endtask

  // point driver
  always @(posedge clk) begin
    if (rst) begin
      point_bus.valid <= 1'b0;
    end else begin
      if (point_bus.valid && point_bus.ready)
        take_point(point_bus.point_x, point_bus.point_y, point_bus.curve_start);
      if (!point_bus.valid || point_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          point_bus.valid <= 1'b0;
        end else if (point_feed.size() != 0) begin
          ctrl_point_t p;
          p = point_feed.pop_front();
          point_bus.valid       <= 1'b1;
          point_bus.point_x     <= p.x;
          point_bus.point_y     <= p.y;
          point_bus.curve_start <= p.start;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
          end
        end else begin
          point_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_ack  <= 0;
    end else if (hold_ack != hold_seq) begin
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_seq;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // sample monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      sample_bus.ready <= 1'b0;
    end else begin
      if (sample_bus.valid && sample_bus.ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample beat: x=%0d y=%0d last=%0b",
                 sample_bus.sample_x, sample_bus.sample_y, sample_bus.segment_last);
          error_count++;
        end else begin
          got = expected_samples.pop_front();
          if (sample_bus.sample_x !== got.x) begin
            $error("sample_x: expected %0d, actual %0d", got.x, sample_bus.sample_x);
            error_count++;
          end
          if (sample_bus.sample_y !== got.y) begin
            $error("sample_y: expected %0d, actual %0d", got.y, sample_bus.sample_y);
            error_count++;
          end
          if (sample_bus.segment_last !== got.last) begin
            $error("segment_last: expected %0b, actual %0b", got.last,
                   sample_bus.segment_last);
            error_count++;
          end
        end
      end
      rx_cycles++;
      if (rx_cycles % 256 == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 85;
          2: ready_pct = 50;
          default: ready_pct = 20;
        endcase
      end
      sample_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) < ready_pct);
    end
  end

  task automatic push_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y, input logic start);
    ctrl_point_t p;
    p.x     = x;
    p.y     = y;
    p.start = start;
    point_feed = {point_feed, p};
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return C_MAX;
          1: return C_MIN;
          2: return '0;
          default: return -24'sd1;
        endcase
      end
      1: return COORD_W'($urandom_range(0, 4000) - 2000);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // mostly clean curves; some carry stray start flags or leftover points
  task automatic add_random_curve(output int added);
    int  nseg;
    int  trailing;
    bit  noisy;
    nseg     = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    trailing = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
    noisy    = ($urandom_range(0, 6) == 0);
    push_point(rand_coord(), rand_coord(), $urandom_range(0, 9) != 0);
    for (int i = 0; i < 3 * nseg + trailing; i++)
      push_point(rand_coord(), rand_coord(), noisy ? ($urandom_range(0, 3) == 0) : 1'b0);
    added = 1 + 3 * nseg + trailing;
  endtask

  function automatic logic [STEP_W-1:0] rand_step();
    case ($urandom_range(0, 6))
      0: return 17'd1024;
      1: return 17'd65535;
      2: return 17'd65536;
      3: return 17'd1;
      4: return STEP_W'($urandom_range(1024, 65536));
      5: return STEP_W'($urandom_range(8192, 65536));
      default: return STEP_W'($urandom);
    endcase
  endfunction

  task automatic apb_write(input logic idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_T_STEP) step_cfg = data[STEP_W-1:0];
  endtask

  task automatic wait_idle();
    while (point_feed.size() != 0 || point_bus.valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int added;
    int n;
    logic [STEP_W-1:0] stp;
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    seg_phase = 2'd0;
    anchored  = 1'b0;
    step_cfg  = T_STEP_INIT;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset step: unflagged first point anchors, chained segments, leftovers, restart
    push_point(C_MAX, C_MAX, 1'b0);
    push_point(C_MIN, C_MIN, 1'b0);
    push_point(C_MAX, C_MIN, 1'b0);
    push_point(C_MIN, C_MAX, 1'b0);
    push_point('0, '0, 1'b0);
    push_point(C_MAX, '0, 1'b0);
    push_point(-24'sd1, 24'sd1, 1'b0);
    push_point(24'sd5, -24'sd5, 1'b0);
    push_point(C_MIN, C_MIN, 1'b1);
    push_point(C_MIN, C_MAX, 1'b0);
    push_point(C_MAX, C_MIN, 1'b0);
    push_point(C_MAX, C_MAX, 1'b0);
    push_point(C_MAX, C_MIN, 1'b1);
    wait_idle();

    // zero step: every sample sits at t = 0
    apb_write(REG_T_STEP, 32'd0);
    push_point(24'sd1, 24'sd2, 1'b0);
    push_point(24'sd3, 24'sd4, 1'b0);
    push_point(-24'sd7, 24'sd9, 1'b0);
    wait_idle();

    // step of exactly one: single flagged sample
    apb_write(REG_T_STEP, 32'd65536);
    push_point(24'sd100, 24'sd200, 1'b1);
    push_point(C_MAX, C_MAX, 1'b0);
    push_point(C_MIN, C_MIN, 1'b0);
    push_point(24'sd7, 24'sd7, 1'b0);
    wait_idle();

    // largest step with junk in the upper bits, then a write to an empty slot
    apb_write(REG_T_STEP, 32'hFFFF_FFFF);
    apb_write(REG_UNUSED, 32'h0000_0400);
    push_point(-24'sd100, 24'sd50, 1'b1);
    push_point(C_MIN, C_MAX, 1'b0);
    push_point(24'sd12345, -24'sd999, 1'b0);
    push_point(C_MAX, C_MIN, 1'b0);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: stp = 17'd1024;
        1: stp = 17'd65536;
        default: stp = rand_step();
      endcase
      apb_write(REG_T_STEP, ($urandom & 32'hFFFE_0000) | 32'(stp));
      added = 0;
      while (added < PHASE_ITEMS) begin
        add_random_curve(n);
        added += n;
      end
      if (ph == 2) hold_seq <= hold_seq + 1;
      wait_idle();
    end

    if (error_count == 0)
      $display("PASS cubic_bezier_curve_sampler_top");
    else
      $display("FAIL cubic_bezier_curve_sampler_top");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL cubic_bezier_curve_sampler_top");
    $finish;
  end

endmodule

// File: files.f
design/cbs_pkg.sv
design/cbs_stream_ifs.sv
design/cbs_mul.sv
design/cbs_eval.sv
design/cubic_bezier_curve_sampler_top.sv
design/cbs_checker.sv
tb/sv/cubic_bezier_curve_sampler_top_tb.sv
